// File: design/operation_latency_histogram_bank_assert.svh
// Assertion macros for the latency histogram bank.
`ifndef OPERATION_LATENCY_HISTOGRAM_BANK_ASSERT_SVH
`define OPERATION_LATENCY_HISTOGRAM_BANK_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define OLHB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define OLHB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: design/olhb_pkg.sv
// Package: constants and types shared by the histogram bank modules.
`timescale 1ns / 1ps
package olhb_pkg;
  localparam int SLOTS_DEF   = 6;
  localparam int BUCKETS_DEF = 32;

  localparam logic [2:0] CMD_RECORD  = 3'd0;
  localparam logic [2:0] CMD_RETRY   = 3'd1;
  localparam logic [2:0] CMD_PCTL    = 3'd2;
  localparam logic [2:0] CMD_SUMMARY = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;      // capture input word, start of item
    logic clr_step;  // clear one bucket row entry / slot
    logic rec_rd;    // read bucket for record
    logic rec_wr;    // write bucket and slot stats
    logic retry;     // bump retry counter
    logic rank;      // compute rank
    logic walk_rd;   // issue bucket read for walk
    logic walk_acc;  // accumulate returned bucket
    logic out_pct;   // load percentile answer
    logic out_sum;   // load summary answer
  } olhb_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic clr_done;
    logic walk_hit;
    logic walk_last;
    logic slot_ok;
    logic empty;
  } olhb_sts_t;
endpackage

// File: design/olhb_datapath.sv
// Datapath: bucket memory, per-slot statistics, percentile walk and result register.
`timescale 1ns / 1ps
module olhb_datapath #(
  parameter int SLOTS   = 6,
  parameter int BUCKETS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  olhb_pkg::olhb_cmd_t  cmd,
  output olhb_pkg::olhb_sts_t  sts,
  input  logic [2:0]           in_command,
  input  logic [2:0]           in_slot,
  input  logic [31:0]          in_duration_us,
  input  logic                 in_failed_flag,
  input  logic [16:0]          in_percentile_q16,
  output logic                 res_kind,
  output logic [30:0]          res_value_us,
  output logic [31:0]          res_sample_count,
  output logic [62:0]          res_total_us,
  output logic [30:0]          res_min_us,
  output logic [30:0]          res_max_us,
  output logic [31:0]          res_succeeded_count,
  output logic [31:0]          res_failed_count,
  output logic [31:0]          res_retried_count
);
  import olhb_pkg::*;

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BW    = $clog2(BUCKETS);
  localparam int DEPTH = SLOTS * BUCKETS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [31:0] CNT_MAX = '1;
  localparam logic [62:0] TOT_MAX = '1;

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  logic [SW-1:0] slot_r;
  logic        ok_r;
  logic [30:0] us_r;
  logic [BW-1:0] bkt_r;
  logic        failed_r;
  logic [16:0] pct_r;
  logic [31:0] rank_r;
  logic [32:0] cum_r;
  logic [BW-1:0] wb_r;
  logic [AW-1:0] clr_r;

  logic [31:0] samp_r [SLOTS];
  logic [62:0] tot_r  [SLOTS];
  logic [31:0] min_r  [SLOTS];
  logic [30:0] max_r  [SLOTS];
  logic [31:0] succ_r [SLOTS];
  logic [31:0] fail_r [SLOTS];
  logic [31:0] retr_r [SLOTS];

  // Bucket index of the clamped duration: one above the top set bit (zero for zero), capped at BUCKETS-1.
  logic [30:0] us_in;
  logic [BW-1:0] bkt_in;
  always_comb begin
    logic [5:0] b;
    us_in = in_duration_us[31] ? 31'd0 : in_duration_us[30:0];
    b = '0;
    for (int i = 0; i < 31; i++) begin
      if (us_in[i]) b = 6'(i + 1);
    end
    if (b > 6'(BUCKETS - 1)) bkt_in = BW'(BUCKETS - 1);
    else bkt_in = b[BW-1:0];
  end

  logic [AW-1:0] base;
  assign base = AW'(slot_r) * AW'(BUCKETS);
  logic [AW-1:0] rd_addr;
  always_comb begin
    if (cmd.walk_rd) rd_addr = base + AW'(wb_r);
    else rd_addr = base + AW'(bkt_r);
  end

  logic [32:0] rank_prod;
  logic [16:0] pcl;
  logic [48:0] prod;
  assign pcl  = (pct_r > 17'd65536) ? 17'd65536 : pct_r;
  assign prod = 49'(pcl) * 49'(samp_r[slot_r]) + 49'd65535;
  assign rank_prod = prod[48:16];

  logic [32:0] cum_nxt;
  assign cum_nxt = cum_r + 33'(rd_data_r);

  logic [30:0] ub;
  assign ub = (wb_r == '0) ? 31'd0 : 31'((64'd1 << wb_r) - 64'd1);

  logic [63:0] tot_sum;
  assign tot_sum = 64'(tot_r[slot_r]) + 64'(us_r);

  always_ff @(posedge clk) begin
    if (cmd.rec_wr && ok_r) mem[rd_addr] <= (rd_data_r == CNT_MAX) ? CNT_MAX : rd_data_r + 32'd1;
    else if (cmd.clr_step) mem[clr_r] <= '0;
    rd_data_r <= mem[rd_addr];
  end

  // Clear pointer starts from zero after reset and at every new word.
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.load) clr_r <= '0;
    else if (cmd.clr_step) clr_r <= clr_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_r   <= SW'(in_slot);
      ok_r     <= 32'(in_slot) < SLOTS;
      us_r     <= us_in;
      bkt_r    <= bkt_in;
      failed_r <= in_failed_flag;
      pct_r    <= in_percentile_q16;
      cum_r    <= '0;
      wb_r     <= '0;
    end
    if (cmd.clr_step) begin
      if (32'(clr_r) < SLOTS) begin
        samp_r[SW'(clr_r)] <= '0;
        tot_r[SW'(clr_r)]  <= '0;
        min_r[SW'(clr_r)]  <= '1;
        max_r[SW'(clr_r)]  <= '0;
        succ_r[SW'(clr_r)] <= '0;
        fail_r[SW'(clr_r)] <= '0;
        retr_r[SW'(clr_r)] <= '0;
      end
    end
    if (cmd.rec_wr && ok_r) begin
      if (failed_r) fail_r[slot_r] <= (fail_r[slot_r] == CNT_MAX) ? CNT_MAX : fail_r[slot_r] + 1;
      else succ_r[slot_r] <= (succ_r[slot_r] == CNT_MAX) ? CNT_MAX : succ_r[slot_r] + 1;
      samp_r[slot_r] <= (samp_r[slot_r] == CNT_MAX) ? CNT_MAX : samp_r[slot_r] + 1;
      tot_r[slot_r]  <= tot_sum[63] ? TOT_MAX : tot_sum[62:0];
      if (32'(us_r) < min_r[slot_r]) min_r[slot_r] <= 32'(us_r);
      if (us_r > max_r[slot_r]) max_r[slot_r] <= us_r;
    end
    if (cmd.retry && ok_r)
      retr_r[slot_r] <= (retr_r[slot_r] == CNT_MAX) ? CNT_MAX : retr_r[slot_r] + 1;
    if (cmd.rank) rank_r <= (rank_prod == '0) ? 32'd1 : rank_prod[31:0];
    if (cmd.walk_acc) begin
      cum_r <= cum_nxt;
      if (!sts.walk_hit) wb_r <= wb_r + BW'(1);
    end
    if (cmd.out_pct) begin
      res_kind <= 1'b0;
      if (!ok_r || samp_r[slot_r] == '0) res_value_us <= '0;
      else if (sts.walk_hit) res_value_us <= (ub < max_r[slot_r]) ? ub : max_r[slot_r];
      else res_value_us <= max_r[slot_r];
      res_sample_count <= '0; res_total_us <= '0; res_min_us <= '0; res_max_us <= '0;
      res_succeeded_count <= '0; res_failed_count <= '0; res_retried_count <= '0;
    end
    if (cmd.out_sum) begin
      res_kind <= 1'b1;
      res_value_us <= '0;
      if (ok_r) begin
        res_sample_count    <= samp_r[slot_r];
        res_total_us        <= tot_r[slot_r];
        res_min_us          <= (min_r[slot_r] == CNT_MAX) ? 31'd0 : min_r[slot_r][30:0];
        res_max_us          <= max_r[slot_r];
        res_succeeded_count <= succ_r[slot_r];
        res_failed_count    <= fail_r[slot_r];
        res_retried_count   <= retr_r[slot_r];
      end else begin
        res_sample_count <= '0; res_total_us <= '0; res_min_us <= '0; res_max_us <= '0;
        res_succeeded_count <= '0; res_failed_count <= '0; res_retried_count <= '0;
      end
    end
  end

  assign sts.clr_done  = (32'(clr_r) == DEPTH - 1);
  assign sts.walk_hit  = cum_nxt >= 33'(rank_r);
  assign sts.walk_last = (32'(wb_r) == BUCKETS - 1);
  assign sts.slot_ok   = ok_r;
  assign sts.empty     = (samp_r[slot_r] == '0);
endmodule

// File: design/olhb_ctrl.sv
// Controller: sequences each command word and the output handshake.
`timescale 1ns / 1ps
module olhb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_command,
  output logic                out_valid,
  input  logic                out_ready,
  output olhb_pkg::olhb_cmd_t cmd,
  input  olhb_pkg::olhb_sts_t sts,
  output logic                busy
);
  import olhb_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DECODE, S_REC_RD, S_REC_WAIT, S_REC_WR,
    S_RANK, S_WALK_RD, S_WALK_WAIT, S_WALK_ACC, S_CLEAR
  } state_t;

  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [2:0] op_r;

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd = '0;
    unique case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (op_r)
          CMD_RECORD: state_nxt = S_REC_RD;
          CMD_RETRY: begin cmd.retry = 1'b1; state_nxt = S_IDLE; end
          CMD_PCTL: begin
            if (!sts.slot_ok || sts.empty) begin
              cmd.out_pct = 1'b1; out_valid_nxt = 1'b1; state_nxt = S_IDLE;
            end else state_nxt = S_RANK;
          end
          CMD_SUMMARY: begin cmd.out_sum = 1'b1; out_valid_nxt = 1'b1; state_nxt = S_IDLE; end
          CMD_CLEAR: state_nxt = S_CLEAR;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_REC_RD:   state_nxt = S_REC_WAIT;
      S_REC_WAIT: state_nxt = S_REC_WR;
      S_REC_WR: begin cmd.rec_wr = 1'b1; state_nxt = S_IDLE; end
      S_RANK: begin cmd.rank = 1'b1; state_nxt = S_WALK_RD; end
      S_WALK_RD: begin cmd.walk_rd = 1'b1; state_nxt = S_WALK_WAIT; end
      S_WALK_WAIT: begin cmd.walk_rd = 1'b1; state_nxt = S_WALK_ACC; end
      S_WALK_ACC: begin
        if (sts.walk_hit || sts.walk_last) begin
          cmd.out_pct = 1'b1; out_valid_nxt = 1'b1; state_nxt = S_IDLE;
        end else begin
          cmd.walk_acc = 1'b1; state_nxt = S_WALK_RD;
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.load) op_r <= in_command;
  end
endmodule

// File: design/operation_latency_histogram_bank.sv
// Record steps through decode, read, read-wait and write; retry and summary finish in decode;
// percentile ranks, then reads, waits and accumulates per bucket. One word at a time: in_ready
// stays low until the word is done and its result taken. Clear command: after decode, one bucket
// entry per cycle over all SLOTS*BUCKETS entries. Reset: synchronous active-low; afterwards a
// clearing pass runs over all SLOTS*BUCKETS bucket entries with in_ready low.
`timescale 1ns / 1ps
// Top level: histogram bank, controller plus datapath.
module operation_latency_histogram_bank #(
  parameter int SLOTS   = olhb_pkg::SLOTS_DEF,
  parameter int BUCKETS = olhb_pkg::BUCKETS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [2:0]  in_slot,
  input  logic signed [31:0] in_duration_us,
  input  logic        in_failed_flag,
  input  logic [16:0] in_percentile_q16,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [30:0] out_value_us,
  output logic [31:0] out_sample_count,
  output logic [62:0] out_total_us,
  output logic [30:0] out_min_us,
  output logic [30:0] out_max_us,
  output logic [31:0] out_succeeded_count,
  output logic [31:0] out_failed_count,
  output logic [31:0] out_retried_count
);
  import olhb_pkg::*;
`include "operation_latency_histogram_bank_assert.svh"

  olhb_cmd_t cmd;
  olhb_sts_t sts;
  logic busy;

  // Controller owns the handshakes; datapath owns the bucket memory, statistics and results.
  olhb_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_command,
    .out_valid, .out_ready, .cmd, .sts, .busy
  );

  olhb_datapath #(.SLOTS(SLOTS), .BUCKETS(BUCKETS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_command, .in_slot, .in_duration_us(in_duration_us),
    .in_failed_flag, .in_percentile_q16,
    .res_kind(out_result_kind), .res_value_us(out_value_us),
    .res_sample_count(out_sample_count), .res_total_us(out_total_us),
    .res_min_us(out_min_us), .res_max_us(out_max_us),
    .res_succeeded_count(out_succeeded_count), .res_failed_count(out_failed_count),
    .res_retried_count(out_retried_count)
  );

  // Never take a new word while a result is waiting.
  `OLHB_ASSERT_IMP(a_no_accept_pending, out_valid, !in_ready, "accept while result pending")
  // Accepted word makes the block busy next cycle.
  `OLHB_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, busy && !in_ready, "not busy")
  // Percentile and summary result loads never fire together.
  `OLHB_ASSERT_IMP(a_one_out_load, cmd.out_pct, !cmd.out_sum, "two result loads")
endmodule

// File: tb/sv/tb_operation_latency_histogram_bank.sv
// Testbench for the latency histogram bank: random and directed words, scoreboard checks.
`timescale 1ns / 1ps
module tb_operation_latency_histogram_bank;
  import olhb_pkg::*;

  localparam int NSLOT = SLOTS_DEF;
  localparam int NBUCK = BUCKETS_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [31:0] CNT_SAT = 32'hFFFF_FFFF;
  localparam logic [62:0] TOT_SAT = {63{1'b1}};

  // One result word as seen on the out_ port.
  typedef struct packed {
    logic        kind;
    logic [30:0] value;
    logic [31:0] samples;
    logic [62:0] total;
    logic [30:0] min_v;
    logic [30:0] max_v;
    logic [31:0] ok_cnt;
    logic [31:0] fail_cnt;
    logic [31:0] retry_cnt;
  } stats_word_t;

  // Mirror of the slot statistics plus the queue of answers not yet seen.
  class histogram_scoreboard;
    logic [31:0] bucket_cnt[NSLOT][NBUCK];
    logic [31:0] samples[NSLOT];
    logic [62:0] total[NSLOT];
    logic [31:0] min_v[NSLOT];
    logic [30:0] max_v[NSLOT];
    logic [31:0] ok_cnt[NSLOT];
    logic [31:0] fail_cnt[NSLOT];
    logic [31:0] retry_cnt[NSLOT];
    stats_word_t pending_answers[$];
    int errors;

    function void clear_slots();
      for (int s = 0; s < NSLOT; s++) begin
        for (int b = 0; b < NBUCK; b++) bucket_cnt[s][b] = '0;
        samples[s] = '0; total[s] = '0; min_v[s] = '1; max_v[s] = '0;
        ok_cnt[s] = '0; fail_cnt[s] = '0; retry_cnt[s] = '0;
      end
    endfunction

    function logic [31:0] sat_inc(logic [31:0] v);
      return (v == CNT_SAT) ? v : v + 1;
    endfunction

    function logic [30:0] percentile_bound(int s, logic [16:0] p_in);
      longint unsigned p, rank, cum, ub;
      if (samples[s] == 0) return '0;
      p = (p_in > 17'd65536) ? 65536 : p_in;
      rank = (p * samples[s] + 65535) >> 16;
      if (rank < 1) rank = 1;
      cum = 0;
      for (int b = 0; b < NBUCK; b++) begin
        cum += bucket_cnt[s][b];
        if (cum >= rank) begin
          ub = (b == 0) ? 0 : ((64'd1 << b) - 1);
          return (ub < max_v[s]) ? ub[30:0] : max_v[s];
        end
      end
      return max_v[s];
    endfunction

    function void note_input(logic [2:0] cmd, logic [2:0] slot, logic [31:0] dur,
                             logic failed, logic [16:0] p);
      stats_word_t w;
      logic [30:0] us;
      int b;
      logic [63:0] sum;
      bit ok;
      ok = slot < NSLOT;
      w = '0;
      case (cmd)
        CMD_RECORD: if (ok) begin
          us = dur[31] ? '0 : dur[30:0];
          b = 0;
          for (int i = 0; i < 31; i++) if (us[i]) b = i + 1;
          if (b > NBUCK - 1) b = NBUCK - 1;
          if (failed) fail_cnt[slot] = sat_inc(fail_cnt[slot]);
          else ok_cnt[slot] = sat_inc(ok_cnt[slot]);
          bucket_cnt[slot][b] = sat_inc(bucket_cnt[slot][b]);
          samples[slot] = sat_inc(samples[slot]);
          sum = {1'b0, total[slot]} + us;
          total[slot] = sum[63] ? TOT_SAT : sum[62:0];
          if (us < min_v[slot]) min_v[slot] = {1'b0, us};
          if (us > max_v[slot]) max_v[slot] = us;
        end
        CMD_RETRY: if (ok) retry_cnt[slot] = sat_inc(retry_cnt[slot]);
        CMD_PCTL: begin
          if (ok) w.value = percentile_bound(slot, p);
          pending_answers.push_back(w);
        end
        CMD_SUMMARY: begin
          w.kind = 1'b1;
          if (ok) begin
            w.samples = samples[slot];
            w.total = total[slot];
            w.min_v = (min_v[slot] == CNT_SAT) ? '0 : min_v[slot][30:0];
            w.max_v = max_v[slot];
            w.ok_cnt = ok_cnt[slot];
            w.fail_cnt = fail_cnt[slot];
            w.retry_cnt = retry_cnt[slot];
          end
          pending_answers.push_back(w);
        end
        CMD_CLEAR: clear_slots();
        default: ;
      endcase
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(stats_word_t got);
      stats_word_t e;
      if (pending_answers.size() == 0) begin
        report("unexpected word", 1, 0);
        return;
      end
      e = pending_answers.pop_front();
      if (got.kind !== e.kind) report("result_kind", got.kind, e.kind);
      if (got.value !== e.value) report("value_us", got.value, e.value);
      if (got.samples !== e.samples) report("sample_count", got.samples, e.samples);
      if (got.total !== e.total) report("total_us", got.total, e.total);
      if (got.min_v !== e.min_v) report("min_us", got.min_v, e.min_v);
      if (got.max_v !== e.max_v) report("max_us", got.max_v, e.max_v);
      if (got.ok_cnt !== e.ok_cnt) report("succeeded_count", got.ok_cnt, e.ok_cnt);
      if (got.fail_cnt !== e.fail_cnt) report("failed_count", got.fail_cnt, e.fail_cnt);
      if (got.retry_cnt !== e.retry_cnt) report("retried_count", got.retry_cnt, e.retry_cnt);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_command = '0;
  logic [2:0] in_slot = '0;
  logic signed [31:0] in_duration_us = '0;
  logic in_failed_flag = 1'b0;
  logic [16:0] in_percentile_q16 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_result_kind;
  logic [30:0] out_value_us, out_min_us, out_max_us;
  logic [31:0] out_sample_count, out_succeeded_count, out_failed_count, out_retried_count;
  logic [62:0] out_total_us;

  histogram_scoreboard stats_sb;
  int sender_idle_pct = 0;    // chance of a gap after each input word
  int receiver_stall_pct = 0; // chance of out_ready low in a cycle
  int hold_off_cycles = 0;    // long receiver hold-off, counted down below
  int hold_request = 0;
  int cycle_count = 0;

  operation_latency_histogram_bank i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_slot, .in_duration_us,
    .in_failed_flag, .in_percentile_q16, .out_valid, .out_ready, .out_result_kind,
    .out_value_us, .out_sample_count, .out_total_us, .out_min_us, .out_max_us,
    .out_succeeded_count, .out_failed_count, .out_retried_count
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog: a stuck handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_operation_latency_histogram_bank failed");
      $finish;
    end
  end

  // Long hold-off counter, loaded on request from the stimulus.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_off_cycles <= hold_request;
      hold_request <= 0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
    end
  end

  // Receiver: check each accepted result word, then choose the next ready.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      stats_sb.check_result({out_result_kind, out_value_us, out_sample_count, out_total_us,
                             out_min_us, out_max_us, out_succeeded_count,
                             out_failed_count, out_retried_count});
    out_ready <= rst_n && hold_off_cycles == 0 && hold_request == 0 &&
                 ($urandom_range(99) >= receiver_stall_pct);
  end

  // Offer one input word and hold it until accepted; gap afterwards at random.
  task send_word(logic [2:0] cmd, logic [2:0] slot, logic [31:0] dur, logic failed,
                 logic [16:0] p);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_slot <= slot;
    in_duration_us <= dur;
    in_failed_flag <= failed;
    in_percentile_q16 <= p;
    do @(posedge clk); while (!in_ready);
    stats_sb.note_input(cmd, slot, dur, failed, p);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // Durations spread over every bucket, with negatives and extremes mixed in.
  function logic [31:0] pick_duration();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'h8000_0000 | $urandom;
      2: return 32'h7FFF_FFFF - $urandom_range(3);
      3: return $urandom_range(3);
      default: return $urandom & ((32'd1 << $urandom_range(31)) - 1);
    endcase
  endfunction

  function logic [16:0] pick_fraction();
    case ($urandom_range(5))
      0: return 17'($urandom_range(131071));
      1: return 17'd65536;
      2: return 17'($urandom_range(3));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  // Random words: mostly records and queries on valid slots, some noise.
  task send_random_word();
    int r;
    logic [2:0] cmd, slot;
    r = $urandom_range(199);
    slot = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(NSLOT - 1));
    if (r < 90) cmd = CMD_RECORD;
    else if (r < 110) cmd = CMD_RETRY;
    else if (r < 155) cmd = CMD_PCTL;
    else if (r < 193) cmd = CMD_SUMMARY;
    else if (r < 195) cmd = CMD_CLEAR;
    else cmd = 3'(5 + $urandom_range(2));
    send_word(cmd, slot, pick_duration(), 1'($urandom_range(1)), pick_fraction());
  endtask

  task wait_drained();
    while (stats_sb.pending_answers.size() != 0) @(posedge clk);
  endtask

  initial begin
    stats_sb = new();
    stats_sb.clear_slots();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty slot, extremes of duration and fraction, bad slots, unused codes.
    send_word(CMD_SUMMARY, 3'd0, '0, 1'b0, '0);
    send_word(CMD_PCTL, 3'd0, '0, 1'b0, 17'd65536);
    send_word(CMD_RECORD, 3'd0, 32'd0, 1'b0, '0);
    send_word(CMD_RECORD, 3'd0, 32'h7FFF_FFFF, 1'b1, '0);
    send_word(CMD_RECORD, 3'd0, 32'hFFFF_FFFF, 1'b0, '0);
    send_word(CMD_RECORD, 3'd0, 32'h8000_0000, 1'b1, '0);
    send_word(CMD_RECORD, 3'd0, 32'h4000_0000, 1'b0, '0);
    send_word(CMD_RECORD, 3'd0, 32'd5, 1'b0, '0);
    send_word(CMD_RETRY, 3'd0, '0, 1'b0, '0);
    send_word(CMD_PCTL, 3'd0, '0, 1'b0, 17'd0);
    send_word(CMD_PCTL, 3'd0, '0, 1'b0, 17'd65536);
    send_word(CMD_PCTL, 3'd0, '0, 1'b0, 17'h1FFFF);
    send_word(CMD_PCTL, 3'd0, '0, 1'b0, 17'd40000);
    send_word(CMD_SUMMARY, 3'd0, '0, 1'b0, '0);
    send_word(CMD_RECORD, 3'd6, 32'd9, 1'b0, '0);
    send_word(CMD_RETRY, 3'd7, '0, 1'b0, '0);
    send_word(CMD_PCTL, 3'd7, '0, 1'b0, 17'd65536);
    send_word(CMD_SUMMARY, 3'd6, '0, 1'b0, '0);
    send_word(3'd5, 3'd0, '0, 1'b0, '0);
    send_word(3'd6, 3'd1, '0, 1'b1, '0);
    send_word(3'd7, 3'd2, '0, 1'b0, '0);
    send_word(CMD_RECORD, 3'd5, 32'd1, 1'b1, '0);
    send_word(CMD_CLEAR, 3'd0, '0, 1'b0, '0);
    send_word(CMD_SUMMARY, 3'd0, '0, 1'b0, '0);
    send_word(CMD_SUMMARY, 3'd5, '0, 1'b0, '0);

    // Long receiver hold-off while the sender keeps offering queries.
    hold_request <= 400;
    for (int i = 0; i < 30; i++) send_word(CMD_SUMMARY, 3'(i % NSLOT), '0, 1'b0, '0);

    // Four idling phases: none, sender idle, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = (ph == 1) ? 70 : (ph == 3) ? 20 : 0;
      receiver_stall_pct = (ph == 2) ? 70 : (ph == 3) ? 20 : 0;
      for (int i = 0; i < 450; i++) send_random_word();
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (300) @(posedge clk);
    if (stats_sb.errors == 0 && stats_sb.pending_answers.size() == 0) begin
      $display("tb_operation_latency_histogram_bank passed");
    end else begin
      $display("tb_operation_latency_histogram_bank failed");
    end
    $finish;
  end
endmodule
